[rtl/core/erl_pkg.sv]
// Shared types, constants and command/status bundles for the ring record log.
package erl_pkg;

  localparam int HEADER_BYTES          = 2;
  localparam int DEF_RECORD_TEXT_BYTES = 14;
  localparam int DEF_MAX_RECORDS       = 15;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;
  localparam logic [7:0] TERM_BYTE   = 8'h00;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTORE = 2'd2,
    OP_ERASE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BLANK     = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic wr_exec;
    logic rst_exec;
    logic rd_start;
    logic rd_issue;
    logic rd_emit;
    logic emit_term;
    logic emit_bad;
    logic er_start;
    logic er_step;
    logic er_emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    idx_bad;
    logic    out_free;
    logic    rd_last;
    logic    er_last;
  } stat_t;

endpackage

[rtl/core/eeprom_ring_record_log_top.sv]
// Top level of the ring record log: controller, datapath and checks.
//
// Requests arrive on in_valid/in_ready with opcode, data_byte and record_index;
// results leave on out_valid/out_ready, each carrying every output field.
// One request is worked on at a time; in_ready is high only while idle.
// Steps per request, after acceptance and a dispatch state:
//   write, restore: one result.
//   read: each text byte is fetched from the record store (registered read
//     port) and then shown, then the terminator. A bad index gives one result.
//   erase: one record-area byte per cycle over all (RECORD_TEXT_BYTES+1)*MAX_RECORDS
//     bytes (225 by default), then one result.
// After reset the block sweeps the record area to 0xFF, one byte per cycle
// (225 bytes by default), before in_ready rises.
// The result register holds each result until out_ready takes it; a stalled
// receiver pauses the controller without losing or repeating a result, and
// the next request may be accepted while the final result still waits.
module eeprom_ring_record_log_top #(
  parameter int RECORD_TEXT_BYTES = erl_pkg::DEF_RECORD_TEXT_BYTES,
  parameter int MAX_RECORDS       = erl_pkg::DEF_MAX_RECORDS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] record_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_byte,
  output logic       last,
  output logic [1:0] status,
  output logic       record_done,
  output logic [7:0] write_address,
  output logic [3:0] record_count,
  output logic       wrap_seen
);
  import erl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  erl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  erl_dpath #(
    .RECORD_TEXT_BYTES(RECORD_TEXT_BYTES),
    .MAX_RECORDS      (MAX_RECORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .record_index (record_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .last         (last),
    .status       (status),
    .record_done  (record_done),
    .write_address(write_address),
    .record_count (record_count),
    .wrap_seen    (wrap_seen)
  );

`ifndef SYNTHESIS
  // A request is worked on alone, so acceptance closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> record_count <= 4'(MAX_RECORDS))
    else $error("record count above maximum");

  // A committed record and a rejected index each end their request.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_done || status == ST_BAD_INDEX) |-> last && read_byte == TERM_BYTE)
    else $error("single-result request not marked last");

  a_addr_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && (HEADER_BYTES + (RECORD_TEXT_BYTES + 1) * MAX_RECORDS <= 256)
      |-> write_address >= 8'(HEADER_BYTES))
    else $error("write address inside the header");
`endif

endmodule

[rtl/core/erl_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module erl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/erl_ctrl.sv]
// Controller state machine for the ring record log.
module erl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  erl_pkg::stat_t stat,
  output erl_pkg::cmd_t  cmd
);
  import erl_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_WRITE, S_RESTORE, S_RD_ISSUE,
    S_RD_EMIT, S_TERM, S_BAD, S_ERASE, S_ER_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.er_step = 1'b1;
        if (stat.er_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_WRITE:   state_next = S_WRITE;
          OP_RESTORE: state_next = S_RESTORE;
          OP_READ: begin
            if (stat.idx_bad) begin
              state_next = S_BAD;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = S_RD_ISSUE;
            end
          end
          OP_ERASE: begin
            cmd.er_start = 1'b1;
            state_next   = S_ERASE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.wr_exec = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_RESTORE: begin
        if (stat.out_free) begin
          cmd.rst_exec = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next  = stat.rd_last ? S_TERM : S_RD_ISSUE;
        end
      end
      S_TERM: begin
        if (stat.out_free) begin
          cmd.emit_term = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_BAD: begin
        if (stat.out_free) begin
          cmd.emit_bad = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ERASE: begin
        cmd.er_step = 1'b1;
        if (stat.er_last) state_next = S_ER_EMIT;
      end
      S_ER_EMIT: begin
        if (stat.out_free) begin
          cmd.er_emit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

[rtl/core/erl_dpath.sv]
// Datapath of the ring record log: pointers, header copy, record store, result register.
module erl_dpath #(
  parameter int RECORD_TEXT_BYTES = erl_pkg::DEF_RECORD_TEXT_BYTES,
  parameter int MAX_RECORDS       = erl_pkg::DEF_MAX_RECORDS
) (
  input  logic           clk,
  input  logic           rst,
  input  erl_pkg::cmd_t  cmd,
  output erl_pkg::stat_t stat,
  input  logic [1:0]     opcode,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     record_index,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_byte,
  output logic           last,
  output logic [1:0]     status,
  output logic           record_done,
  output logic [7:0]     write_address,
  output logic [3:0]     record_count,
  output logic           wrap_seen
);
  import erl_pkg::*;

  localparam int RECORD_BYTES = RECORD_TEXT_BYTES + 1;
  localparam int AREA_BYTES   = RECORD_BYTES * MAX_RECORDS;
  localparam int STORE_BYTES  = HEADER_BYTES + AREA_BYTES;
  localparam int PTR_W        = $clog2(STORE_BYTES);
  localparam int SUM_W        = PTR_W + 1;
  localparam int RAM_AW       = $clog2(AREA_BYTES);
  localparam int WBI_W        = $clog2(RECORD_BYTES);
  localparam logic [15:0] STORE_LIM = 16'(STORE_BYTES);

  // Latched request.
  opcode_t    op_q;
  logic [7:0] data_q;
  logic [7:0] idx_q;

  logic [PTR_W-1:0]  ptr;
  logic [3:0]        cnt;
  logic              full;
  logic [WBI_W-1:0]  wbi;
  logic [7:0]        hd0, hd1;
  logic [RAM_AW-1:0] rd_base;
  logic [WBI_W-1:0]  ti;
  logic [RAM_AW-1:0] er_cnt;

  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Write step.
  logic [SUM_W-1:0] wr_sum, adv;
  logic             wr_in, commit, wrap;
  logic [PTR_W-1:0] ptr_w_next;
  logic [3:0]       cnt_w_next;
  logic             full_w_next;

  always_comb begin
    wr_sum      = SUM_W'(ptr) + SUM_W'(wbi);
    wr_in       = wr_sum < SUM_W'(STORE_BYTES);
    commit      = (wbi == WBI_W'(RECORD_BYTES - 1));
    adv         = SUM_W'(ptr) + SUM_W'(RECORD_BYTES);
    wrap        = adv >= SUM_W'(STORE_BYTES);
    ptr_w_next  = ptr;
    cnt_w_next  = cnt;
    full_w_next = full;
    if (commit) begin
      ptr_w_next  = wrap ? PTR_W'(HEADER_BYTES) : PTR_W'(adv);
      cnt_w_next  = (cnt < 4'(MAX_RECORDS)) ? cnt + 4'd1 : cnt;
      full_w_next = full | wrap;
    end
  end

  // Restore from the header copy.
  logic             blank, p_ok;
  logic [3:0]       c_clamp;
  logic [PTR_W-1:0] ptr_r_next;
  logic [3:0]       cnt_r_next;
  logic             full_r_next;

  always_comb begin
    blank       = (hd0 == ERASED_BYTE) || (hd1 == ERASED_BYTE) || (hd1 == 8'd0);
    p_ok        = (hd0 >= 8'(HEADER_BYTES)) && (16'(hd0) < STORE_LIM);
    c_clamp     = (hd1 > 8'(MAX_RECORDS)) ? 4'(MAX_RECORDS) : hd1[3:0];
    ptr_r_next  = (blank || !p_ok) ? PTR_W'(HEADER_BYTES) : PTR_W'(hd0);
    cnt_r_next  = blank ? 4'd0 : c_clamp;
    full_r_next = !blank && (c_clamp == 4'(MAX_RECORDS));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = er_cnt;
    ram_wdata = ERASED_BYTE;
    if (cmd.er_step) begin
      ram_we = 1'b1;
    end else if (cmd.wr_exec && wr_in) begin
      ram_we    = 1'b1;
      ram_waddr = RAM_AW'(wr_sum - SUM_W'(HEADER_BYTES));
      ram_wdata = data_q;
    end
    ram_re    = cmd.rd_issue;
    ram_raddr = rd_base + RAM_AW'(ti);
  end

  erl_ram #(
    .WIDTH(8),
    .DEPTH(AREA_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stat.op       = op_q;
    stat.idx_bad  = idx_q >= 8'(MAX_RECORDS);
    stat.out_free = !out_valid || out_ready;
    stat.rd_last  = (ti == WBI_W'(RECORD_TEXT_BYTES - 1));
    stat.er_last  = (er_cnt == RAM_AW'(AREA_BYTES - 1));
  end

  // Request latch and read index: payload only.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= opcode_t'(opcode);
      data_q <= data_byte;
      idx_q  <= record_index;
    end
    if (cmd.rd_start) begin
      rd_base <= RAM_AW'(32'(idx_q[3:0]) * RECORD_BYTES);
      ti      <= '0;
    end else if (cmd.rd_emit) begin
      ti <= ti + WBI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= PTR_W'(HEADER_BYTES);
      cnt       <= '0;
      full      <= 1'b0;
      wbi       <= '0;
      hd0       <= ERASED_BYTE;
      hd1       <= ERASED_BYTE;
      er_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_exec) begin
        ptr  <= ptr_w_next;
        cnt  <= cnt_w_next;
        full <= full_w_next;
        wbi  <= commit ? '0 : wbi + WBI_W'(1);
        if (commit) begin
          hd0 <= 8'(ptr_w_next);
          hd1 <= 8'(cnt_w_next);
        end
      end
      if (cmd.rst_exec) begin
        ptr  <= ptr_r_next;
        cnt  <= cnt_r_next;
        full <= full_r_next;
      end
      if (cmd.er_start) begin
        er_cnt <= '0;
        hd0    <= ERASED_BYTE;
        hd1    <= ERASED_BYTE;
      end else if (cmd.er_step) begin
        er_cnt <= er_cnt + RAM_AW'(1);
      end
      if (cmd.wr_exec || cmd.rst_exec || cmd.rd_emit || cmd.emit_term ||
          cmd.emit_bad || cmd.er_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register payload; it always reports the counters after the step.
  always_ff @(posedge clk) begin
    if (cmd.wr_exec) begin
      read_byte     <= TERM_BYTE;
      last          <= 1'b1;
      status        <= ST_OK;
      record_done   <= commit;
      write_address <= 8'(ptr_w_next);
      record_count  <= cnt_w_next;
      wrap_seen     <= full_w_next;
    end else if (cmd.rst_exec) begin
      read_byte     <= TERM_BYTE;
      last          <= 1'b1;
      status        <= blank ? ST_BLANK : ST_OK;
      record_done   <= 1'b0;
      write_address <= 8'(ptr_r_next);
      record_count  <= cnt_r_next;
      wrap_seen     <= full_r_next;
    end else if (cmd.rd_emit || cmd.emit_term || cmd.emit_bad || cmd.er_emit) begin
      read_byte     <= cmd.rd_emit ? ram_rdata : TERM_BYTE;
      last          <= !cmd.rd_emit;
      status        <= cmd.emit_bad ? ST_BAD_INDEX : ST_OK;
      record_done   <= 1'b0;
      write_address <= 8'(ptr);
      record_count  <= cnt;
      wrap_seen     <= full;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the ring record log, with its own prediction of the store.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import erl_pkg::*;

  localparam int TEXT_BYTES  = DEF_RECORD_TEXT_BYTES;
  localparam int REC_BYTES   = TEXT_BYTES + 1;
  localparam int NUM_RECORDS = DEF_MAX_RECORDS;
  localparam int STORE_BYTES = HEADER_BYTES + REC_BYTES * NUM_RECORDS;
  localparam int SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       last;
    status_t    status;
    logic       done;
    logic [7:0] waddr;
    logic [3:0] count;
    logic       full;
  } log_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [7:0] record_index;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_byte;
  logic       last;
  logic [1:0] status;
  logic       record_done;
  logic [7:0] write_address;
  logic [3:0] record_count;
  logic       wrap_seen;

  // Predicted copy of the log state.
  logic [7:0] log_mem [0:STORE_BYTES-1];
  logic [7:0] log_ptr;
  logic [3:0] log_count;
  logic       log_wrapped;
  logic [3:0] log_byte_idx;

  log_result_t owed_results[$];
  int fault_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;

  eeprom_ring_record_log_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .record_index (record_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .last         (last),
    .status       (status),
    .record_done  (record_done),
    .write_address(write_address),
    .record_count (record_count),
    .wrap_seen    (wrap_seen)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // A long hold-off takes precedence over the random stall.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void owe(input logic [7:0] b, input logic l, input status_t s,
                              input logic d);
    log_result_t r;
    r.rd_byte = b;
    r.last    = l;
    r.status  = s;
    r.done    = d;
    r.waddr   = log_ptr;
    r.count   = log_count;
    r.full    = log_wrapped;
    owed_results.push_back(r);
  endfunction

  function automatic void clear_log();
    foreach (log_mem[i]) log_mem[i] = ERASED_BYTE;
  endfunction

  // Updates the predicted state for one accepted request and queues its results.
  function automatic void apply_log_request(input opcode_t op, input logic [7:0] data,
                                            input logic [7:0] idx);
    int addr;
    int base;
    logic [7:0] p;
    logic [7:0] c;
    logic done;
    case (op)
      OP_WRITE: begin
        done = 1'b0;
        addr = int'(log_ptr) + int'(log_byte_idx);
        // A byte that falls past the end of the store is lost.
        if (addr < STORE_BYTES) log_mem[addr] = data;
        log_byte_idx = log_byte_idx + 4'd1;
        if (int'(log_byte_idx) >= REC_BYTES) begin
          log_byte_idx = '0;
          if (int'(log_ptr) + REC_BYTES >= STORE_BYTES) begin
            log_ptr = 8'(HEADER_BYTES);
            log_wrapped = 1'b1;
          end else begin
            log_ptr = 8'(int'(log_ptr) + REC_BYTES);
          end
          if (int'(log_count) < NUM_RECORDS) log_count = log_count + 4'd1;
          log_mem[0] = log_ptr;
          log_mem[1] = 8'(log_count);
          done = 1'b1;
        end
        owe(8'h00, 1'b1, ST_OK, done);
      end
      OP_READ: begin
        if (int'(idx) >= NUM_RECORDS) begin
          owe(8'h00, 1'b1, ST_BAD_INDEX, 1'b0);
        end else begin
          base = HEADER_BYTES + int'(idx) * REC_BYTES;
          for (int i = 0; i < TEXT_BYTES; i++)
            owe((base + i < STORE_BYTES) ? log_mem[base + i] : 8'h00, 1'b0, ST_OK, 1'b0);
          owe(TERM_BYTE, 1'b1, ST_OK, 1'b0);
        end
      end
      OP_RESTORE: begin
        p = log_mem[0];
        c = log_mem[1];
        if (p == ERASED_BYTE || c == ERASED_BYTE || c == 8'h00) begin
          log_ptr = 8'(HEADER_BYTES);
          log_count = '0;
          log_wrapped = 1'b0;
          owe(8'h00, 1'b1, ST_BLANK, 1'b0);
        end else begin
          if (int'(p) < HEADER_BYTES || int'(p) >= STORE_BYTES) p = 8'(HEADER_BYTES);
          if (int'(c) > NUM_RECORDS) c = 8'(NUM_RECORDS);
          log_ptr = p;
          log_count = 4'(c);
          log_wrapped = (int'(c) == NUM_RECORDS);
          owe(8'h00, 1'b1, ST_OK, 1'b0);
        end
      end
      default: begin
        clear_log();
        owe(8'h00, 1'b1, ST_OK, 1'b0);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    log_result_t got;
    log_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.rd_byte = read_byte;
      got.last    = last;
      got.status  = status_t'(status);
      got.done    = record_done;
      got.waddr   = write_address;
      got.count   = record_count;
      got.full    = wrap_seen;
      if (owed_results.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
          $display("%0t: result with nothing expected: byte=%h last=%b status=%0d",
                   $realtime, read_byte, last, status);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $write("%0t: mismatch exp byte=%h last=%b st=%0d done=%b addr=%0d cnt=%0d full=%b",
                   $realtime, want.rd_byte, want.last, want.status, want.done, want.waddr,
                   want.count, want.full);
            $display(" / got byte=%h last=%b st=%0d done=%b addr=%0d cnt=%0d full=%b",
                     got.rd_byte, got.last, got.status, got.done, got.waddr, got.count,
                     got.full);
          end
        end
      end
    end
  end

  // Entered and left at a rising edge; valid stays high when the next request follows.
  task automatic send_request(input opcode_t op, input logic [7:0] data,
                              input logic [7:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    data_byte    <= data;
    record_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_log_request(op, data, idx);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (owed_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    idle_pct  <= sender_pct;
    stall_pct <= receiver_pct;
  endtask

  task automatic test_blank_start();
    send_request(OP_RESTORE, 8'h00, 8'h00);
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_READ, 8'h00, 8'(NUM_RECORDS - 1));
    send_request(OP_READ, 8'h00, 8'(NUM_RECORDS));
    send_request(OP_READ, 8'hFF, 8'hFF);
    wait_drained();
  endtask

  task automatic test_first_record();
    logic [7:0] pattern [0:REC_BYTES-1];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                8'h40, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h01};
    for (int i = 0; i < REC_BYTES; i++) send_request(OP_WRITE, pattern[i], 8'hFF);
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_RESTORE, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_erase();
    send_request(OP_ERASE, 8'h00, 8'h00);
    send_request(OP_RESTORE, 8'h00, 8'h00);
    send_request(OP_READ, 8'h00, 8'd0);
    wait_drained();
  endtask

  // Fills the ring past one full turn while the receiver holds off at the start,
  // then checks restore with a saturated count and a partial record over erase.
  task automatic test_ring_wrap();
    set_idling(0, 0);
    hold_len <= 400;
    for (int i = 0; i < (NUM_RECORDS + 1) * REC_BYTES + 3; i++)
      send_request(OP_WRITE, 8'($urandom), 8'($urandom));
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_READ, 8'h00, 8'(NUM_RECORDS - 1));
    send_request(OP_RESTORE, 8'h00, 8'h00);
    send_request(OP_ERASE, 8'h00, 8'h00);
    send_request(OP_RESTORE, 8'h00, 8'h00);
    while (log_byte_idx != 0) send_request(OP_WRITE, 8'($urandom), 8'h00);
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_RESTORE, 8'h00, 8'h00);
    wait_drained();
  endtask

  // Mostly whole or partial records with random content, mixed with reads,
  // restores, erases and stray writes.
  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n);
    int sent;
    int pick;
    int burst;
    sent = 0;
    set_idling(sender_pct, receiver_pct);
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        burst = ($urandom_range(3) != 0) ? REC_BYTES - int'(log_byte_idx)
                                         : $urandom_range(1, REC_BYTES - 1);
        for (int i = 0; i < burst; i++) send_request(OP_WRITE, 8'($urandom), 8'($urandom));
        sent += burst;
      end else begin
        if (pick < 60)
          send_request(OP_WRITE, 8'($urandom), 8'($urandom));
        else if (pick < 80)
          send_request(OP_READ, 8'($urandom),
                       ($urandom_range(9) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(NUM_RECORDS - 1)));
        else if (pick < 93)
          send_request(OP_RESTORE, 8'($urandom), 8'($urandom));
        else
          send_request(OP_ERASE, 8'($urandom), 8'($urandom));
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_WRITE;
    data_byte    = 8'h00;
    record_index = 8'h00;
    clear_log();
    log_ptr      = 8'(HEADER_BYTES);
    log_count    = '0;
    log_wrapped  = 1'b0;
    log_byte_idx = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_blank_start();
    test_first_record();
    test_erase();
    test_ring_wrap();
    test_random_traffic(0, 0, 30);
    test_random_traffic(79, 0, 30);
    test_random_traffic(0, 79, 30);
    test_random_traffic(29, 29, 30);

    repeat (300) @(posedge clk);
    if (fault_count == 0 && owed_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
